@@ hdl/us2cal_pkg.sv @@
package us2cal_pkg;

  // Field widths of the two channels.
  localparam int SECS_W  = 41;
  localparam int SEC_W   = 6;
  localparam int MIN_W   = 6;
  localparam int HOUR_W  = 5;
  localparam int MDAY_W  = 5;
  localparam int MON_W   = 4;
  localparam int YEAR_W  = 17;
  localparam int WDAY_W  = 3;
  localparam int YDAY_W  = 9;

  // Calendar constants.
  localparam int SECS_PER_DAY   = 86400;
  localparam int SECS_PER_HOUR  = 3600;
  localparam int SECS_PER_MIN   = 60;
  localparam int DAYS_TO_EPOCH  = 719468;   // 0000-03-01 to 1970-01-01
  localparam int DAYS_PER_ERA   = 146097;
  localparam int ERA_LAST_DAY   = 146096;
  localparam int DAYS_PER_CENT  = 36524;
  localparam int DAYS_PER_4Y    = 1460;
  localparam int DAYS_PER_YEAR  = 365;
  localparam int YEARS_PER_ERA  = 400;
  localparam int YEAR_BASE      = 1900;
  localparam int JAN_FEB_DAYS   = 59;
  localparam int MARCH_TO_JAN   = 306;
  localparam int FIRST_JAN_MP   = 10;       // March-based month index of January

  // The seconds are biased by a whole number of eras plus the epoch offset,
  // so that the biased day count is directly a non-negative day number
  // counted from a March 1 that opens an era.
  localparam int ERA_BIAS  = 83;
  localparam int DAY_BIAS  = DAYS_TO_EPOCH + ERA_BIAS * DAYS_PER_ERA;
  localparam longint unsigned SEC_BIAS = longint'(DAY_BIAS) * longint'(SECS_PER_DAY);
  localparam int WDAY_BIAS = (4 - (DAY_BIAS % 7) + 7) % 7;
  localparam int YEAR_BIAS = ERA_BIAS * YEARS_PER_ERA + YEAR_BASE;

  // Widths of the biased seconds and of the day number.
  localparam int SP_W      = SECS_W + 1;
  localparam int DAY_SHIFT = 7;                          // 86400 = 2^7 * 675
  localparam int DAY_ODD   = SECS_PER_DAY >> DAY_SHIFT;
  localparam int X_W       = SP_W - DAY_SHIFT;
  localparam int XL_W      = 17;
  localparam int Q_W       = 25;
  localparam int SOD_W     = 17;
  localparam int ERA_W     = 8;
  localparam int DOE_W     = 18;
  localparam int YOE_W     = 9;
  localparam int DOY_W     = 9;

  // Truncated reciprocals; each estimate is low by at most one.
  localparam longint unsigned RECIP_DAY  = (64'd1 << X_W) / DAY_ODD;
  localparam int RECIP_ERA  = (1 << Q_W) / DAYS_PER_ERA;
  localparam int RECIP_4Y   = (1 << DOE_W) / DAYS_PER_4Y;
  localparam int RECIP_YEAR = (1 << DOE_W) / DAYS_PER_YEAR;
  localparam int RECIP_HOUR = (1 << SOD_W) / SECS_PER_HOUR;
  localparam int RECIP_MIN  = (1 << 12) / SECS_PER_MIN;

  // Time of day and weekday, carried down the date stages.
  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
    logic [WDAY_W-1:0] weekday;
  } tod_t;

  // First day of each March-based month within the year.
  function automatic logic [DOY_W-1:0] month_start(input logic [3:0] mp);
    logic [DOY_W-1:0] d;
    case (mp)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

@@ hdl/unix_seconds_to_calendar_top.sv @@
// Unix time to UTC calendar converter.
//
// Input channel: in_valid / in_stall carry one signed 41-bit count of seconds
// since 1970-01-01 00:00:00 UTC per beat. Output channel: out_valid /
// out_stall carry the broken-down proleptic Gregorian date and time of that
// instant, one result beat per input beat, in order.
//
// The work runs through a 16-stage pipeline: bias and split of the seconds,
// a reciprocal multiply for the day number cut into two partial products,
// then the era and year-of-era steps, each a short multiply followed by a
// one-step correction, and the day-of-year and month steps. One beat is
// accepted in every cycle in which in_stall is low.
//
// The whole pipeline advances as one; when out_stall holds a waiting result,
// in_stall rises in the same cycle and every stage keeps its contents, so
// nothing is lost or repeated. A synchronous low rst_n clears the valid bits
// of all stages; data registers are not reset.
module unix_seconds_to_calendar_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [us2cal_pkg::SECS_W-1:0]   in_unix_seconds,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic        [us2cal_pkg::SEC_W-1:0]    out_second,
  output logic        [us2cal_pkg::MIN_W-1:0]    out_minute,
  output logic        [us2cal_pkg::HOUR_W-1:0]   out_hour,
  output logic        [us2cal_pkg::MDAY_W-1:0]   out_day_of_month,
  output logic        [us2cal_pkg::MON_W-1:0]    out_month_index,
  output logic signed [us2cal_pkg::YEAR_W-1:0]   out_years_since_1900,
  output logic        [us2cal_pkg::WDAY_W-1:0]   out_weekday,
  output logic        [us2cal_pkg::YDAY_W-1:0]   out_day_of_year
);

  localparam int NSTG  = 16;
  localparam int Q_DIG = (us2cal_pkg::Q_W + 2) / 3;
  localparam int DAY_SHIFT_W = us2cal_pkg::DAY_SHIFT;

  logic adv;
  logic [NSTG-1:0] v_r, v_nxt;

  // Stage registers.
  logic [us2cal_pkg::X_W-1:0]       s1_x_r, s1_x_nxt, s2_x_r, s3_x_r;
  logic [DAY_SHIFT_W-1:0]           s1_lo_r, s1_lo_nxt, s2_lo_r, s3_lo_r, s4_lo_r;
  logic [42:0]                      s2_pl_r, s2_pl_nxt;
  logic [43:0]                      s2_ph_r, s2_ph_nxt;
  logic [us2cal_pkg::Q_W-1:0]       s3_qe_r, s3_qe_nxt, s4_qe_r;
  logic [10:0]                      s4_re_r, s4_re_nxt;
  logic [us2cal_pkg::Q_W-1:0]       s5_q_r, s5_q_nxt, s6_q_r;
  logic [us2cal_pkg::SOD_W-1:0]     s5_sod_r, s5_sod_nxt, s6_sod_r;
  logic [us2cal_pkg::ERA_W-1:0]     s6_era_r, s6_era_nxt, s7_era_r;
  logic [5:0]                       s6_ws_r, s6_ws_nxt;
  logic [us2cal_pkg::HOUR_W-1:0]    s6_he_r, s6_he_nxt, s7_h_r, s7_h_nxt, s8_h_r;
  logic [18:0]                      s7_doe_r, s7_doe_nxt;
  logic [us2cal_pkg::WDAY_W-1:0]    s7_wd_r, s7_wd_nxt, s8_wd_r;
  logic [11:0]                      s7_rm_r, s7_rm_nxt, s8_rm_r;
  logic [us2cal_pkg::ERA_W-1:0]     s8_era_r, s8_era_nxt, s9_era_r, s10_era_r;
  logic [us2cal_pkg::ERA_W-1:0]     s11_era_r, s12_era_r, s13_era_r, s14_era_r, s15_era_r;
  logic [us2cal_pkg::DOE_W-1:0]     s8_doe_r, s8_doe_nxt, s9_doe_r, s10_doe_r;
  logic [us2cal_pkg::DOE_W-1:0]     s11_doe_r, s12_doe_r, s13_doe_r;
  logic [us2cal_pkg::MIN_W-1:0]     s8_me_r, s8_me_nxt;
  us2cal_pkg::tod_t                 s9_tod_r, s9_tod_nxt, s10_tod_r, s11_tod_r;
  us2cal_pkg::tod_t                 s12_tod_r, s13_tod_r, s14_tod_r, s15_tod_r;
  logic [6:0]                       s9_c4e_r, s9_c4e_nxt, s10_c4_r, s10_c4_nxt;
  logic [1:0]                       s9_cc_r, s9_cc_nxt, s10_cc_r;
  logic [us2cal_pkg::DOE_W-1:0]     s11_n_r, s11_n_nxt, s12_n_r;
  logic [us2cal_pkg::YOE_W-1:0]     s12_ye_r, s12_ye_nxt;
  logic [us2cal_pkg::YOE_W-1:0]     s13_yoe_r, s13_yoe_nxt, s14_yoe_r;
  logic [us2cal_pkg::DOY_W-1:0]     s14_doy_r, s14_doy_nxt, s15_doy_r;
  logic [3:0]                       s15_mp_r, s15_mp_nxt;
  logic [us2cal_pkg::MDAY_W-1:0]    s15_md_r, s15_md_nxt;
  logic [us2cal_pkg::YOE_W-1:0]     s15_yy_r, s15_yy_nxt;
  logic                             s15_leap_r, s15_leap_nxt;
  logic [us2cal_pkg::MON_W-1:0]     s16_mon_r, s16_mon_nxt;
  logic [us2cal_pkg::YEAR_W-1:0]    s16_year_r, s16_year_nxt;
  logic [us2cal_pkg::YDAY_W-1:0]    s16_yday_r, s16_yday_nxt;
  logic [us2cal_pkg::MDAY_W-1:0]    s16_md_r;
  us2cal_pkg::tod_t                 s16_tod_r;

  // Global advance: the pipeline moves unless a waiting result is stalled.
  assign adv      = !v_r[NSTG-1] || !out_stall;
  assign in_stall = !adv;
  assign v_nxt    = {v_r[NSTG-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= v_nxt;
    end
  end

  // Stage 1: sign-extend and bias the seconds so they are never negative, then split off the low bits.
  always_comb begin
    logic [us2cal_pkg::SP_W-1:0] sp;
    sp = {in_unix_seconds[us2cal_pkg::SECS_W-1], in_unix_seconds}
         + us2cal_pkg::SP_W'(us2cal_pkg::SEC_BIAS);
    s1_x_nxt  = sp[us2cal_pkg::SP_W-1:DAY_SHIFT_W];
    s1_lo_nxt = sp[DAY_SHIFT_W-1:0];
  end

  // Stage 2: partial products of the day-number reciprocal multiply.
  always_comb begin
    s2_pl_nxt = 43'(s1_x_r[us2cal_pkg::XL_W-1:0]) * 43'(us2cal_pkg::RECIP_DAY);
    s2_ph_nxt = 44'(s1_x_r[us2cal_pkg::X_W-1:us2cal_pkg::XL_W]) * 44'(us2cal_pkg::RECIP_DAY);
  end

  // Stage 3: sum the partial products into the day estimate.
  always_comb begin
    logic [60:0] sum;
    sum       = {s2_ph_r, {us2cal_pkg::XL_W{1'b0}}} + 61'(s2_pl_r);
    s3_qe_nxt = sum[us2cal_pkg::X_W+us2cal_pkg::Q_W-1:us2cal_pkg::X_W];
  end

  // Stage 4: remainder of the estimate.
  always_comb begin
    logic [us2cal_pkg::X_W-1:0] prod;
    logic [us2cal_pkg::X_W-1:0] diff;
    prod      = us2cal_pkg::X_W'(s3_qe_r) * us2cal_pkg::X_W'(us2cal_pkg::DAY_ODD);
    diff      = s3_x_r - prod;
    s4_re_nxt = diff[10:0];
  end

  // Stage 5: correct the day number and rebuild the seconds of the day.
  always_comb begin
    logic [10:0] r;
    if (s4_re_r >= 11'(us2cal_pkg::DAY_ODD)) begin
      s5_q_nxt = s4_qe_r + 1'b1;
      r        = s4_re_r - 11'(us2cal_pkg::DAY_ODD);
    end else begin
      s5_q_nxt = s4_qe_r;
      r        = s4_re_r;
    end
    s5_sod_nxt = {r[9:0], s4_lo_r};
  end

  // Stage 6: era and hour estimates, octal digit sum for the weekday.
  always_comb begin
    logic [32:0] pe;
    logic [22:0] ph;
    logic [3*Q_DIG-1:0] qp;
    pe         = 33'(s5_q_r) * 33'(us2cal_pkg::RECIP_ERA);
    s6_era_nxt = pe[us2cal_pkg::Q_W+us2cal_pkg::ERA_W-1:us2cal_pkg::Q_W];
    ph         = 23'(s5_sod_r) * 23'(us2cal_pkg::RECIP_HOUR);
    s6_he_nxt  = ph[us2cal_pkg::SOD_W+us2cal_pkg::HOUR_W-1:us2cal_pkg::SOD_W];
    qp         = (3*Q_DIG)'(s5_q_r);
    s6_ws_nxt  = 6'(us2cal_pkg::WDAY_BIAS);
    for (int i = 0; i < Q_DIG; i++) begin
      s6_ws_nxt = s6_ws_nxt + 6'(qp[3*i +: 3]);
    end
  end

  // Stage 7: day of era estimate, weekday reduction, hour correction.
  always_comb begin
    logic [us2cal_pkg::Q_W-1:0] pe;
    logic [us2cal_pkg::Q_W-1:0] de;
    logic [3:0] t;
    logic [12:0] rh;
    pe          = us2cal_pkg::Q_W'(s6_era_r) * us2cal_pkg::Q_W'(us2cal_pkg::DAYS_PER_ERA);
    de          = s6_q_r - pe;
    s7_doe_nxt  = de[18:0];
    t           = 4'(s6_ws_r[5:3]) + 4'(s6_ws_r[2:0]);
    if (t >= 4'd14) begin
      s7_wd_nxt = 3'(t - 4'd14);
    end else if (t >= 4'd7) begin
      s7_wd_nxt = 3'(t - 4'd7);
    end else begin
      s7_wd_nxt = t[2:0];
    end
    rh = s6_sod_r[12:0] - 13'(13'(s6_he_r) * 13'(us2cal_pkg::SECS_PER_HOUR));
    if (rh >= 13'(us2cal_pkg::SECS_PER_HOUR)) begin
      s7_h_nxt  = s6_he_r + 1'b1;
      rh        = rh - 13'(us2cal_pkg::SECS_PER_HOUR);
    end else begin
      s7_h_nxt  = s6_he_r;
    end
    s7_rm_nxt = rh[11:0];
  end

  // Stage 8: correct the era, estimate the minute.
  always_comb begin
    logic [18:0] pm;
    if (s7_doe_r >= 19'(us2cal_pkg::DAYS_PER_ERA)) begin
      s8_era_nxt = s7_era_r + 1'b1;
      s8_doe_nxt = 18'(s7_doe_r - 19'(us2cal_pkg::DAYS_PER_ERA));
    end else begin
      s8_era_nxt = s7_era_r;
      s8_doe_nxt = s7_doe_r[17:0];
    end
    pm        = 19'(s7_rm_r) * 19'(us2cal_pkg::RECIP_MIN);
    s8_me_nxt = pm[17:12];
  end

  // Stage 9: four-year count estimate, century count, minute correction.
  always_comb begin
    logic [25:0] p4;
    logic [11:0] rs;
    p4         = 26'(s8_doe_r) * 26'(us2cal_pkg::RECIP_4Y);
    s9_c4e_nxt = p4[24:18];
    s9_cc_nxt  = 2'(s8_doe_r >= 18'(us2cal_pkg::DAYS_PER_CENT))
               + 2'(s8_doe_r >= 18'(2 * us2cal_pkg::DAYS_PER_CENT))
               + 2'(s8_doe_r >= 18'(3 * us2cal_pkg::DAYS_PER_CENT));
    rs = s8_rm_r - 12'(12'(s8_me_r) * 12'(us2cal_pkg::SECS_PER_MIN));
    s9_tod_nxt.hour    = s8_h_r;
    s9_tod_nxt.weekday = s8_wd_r;
    if (rs >= 12'(us2cal_pkg::SECS_PER_MIN)) begin
      s9_tod_nxt.minute = s8_me_r + 1'b1;
      s9_tod_nxt.second = 6'(rs - 12'(us2cal_pkg::SECS_PER_MIN));
    end else begin
      s9_tod_nxt.minute = s8_me_r;
      s9_tod_nxt.second = rs[5:0];
    end
  end

  // Stage 10: correct the four-year count.
  always_comb begin
    logic [us2cal_pkg::DOE_W-1:0] r4;
    r4 = s9_doe_r - us2cal_pkg::DOE_W'(us2cal_pkg::DOE_W'(s9_c4e_r)
                                       * us2cal_pkg::DOE_W'(us2cal_pkg::DAYS_PER_4Y));
    if (r4 >= us2cal_pkg::DOE_W'(us2cal_pkg::DAYS_PER_4Y)) begin
      s10_c4_nxt = s9_c4e_r + 1'b1;
    end else begin
      s10_c4_nxt = s9_c4e_r;
    end
  end

  // Stage 11: day of era with leap days removed; a full era day counts as
  // the fourth century, which cancels the last century step.
  assign s11_n_nxt = s10_doe_r - us2cal_pkg::DOE_W'(s10_c4_r)
                   + us2cal_pkg::DOE_W'(s10_cc_r);

  // Stage 12: year of era estimate.
  always_comb begin
    logic [27:0] py;
    py         = 28'(s11_n_r) * 28'(us2cal_pkg::RECIP_YEAR);
    s12_ye_nxt = py[us2cal_pkg::DOE_W+us2cal_pkg::YOE_W-1:us2cal_pkg::DOE_W];
  end

  // Stage 13: correct the year of era.
  always_comb begin
    logic [us2cal_pkg::DOE_W-1:0] ry;
    ry = s12_n_r - us2cal_pkg::DOE_W'(us2cal_pkg::DOE_W'(s12_ye_r)
                                      * us2cal_pkg::DOE_W'(us2cal_pkg::DAYS_PER_YEAR));
    if (ry >= us2cal_pkg::DOE_W'(us2cal_pkg::DAYS_PER_YEAR)) begin
      s13_yoe_nxt = s12_ye_r + 1'b1;
    end else begin
      s13_yoe_nxt = s12_ye_r;
    end
  end

  // Stage 14: day within the March-based year.
  always_comb begin
    logic [1:0] cy;
    logic [us2cal_pkg::DOE_W-1:0] ys;
    logic [us2cal_pkg::DOE_W-1:0] dd;
    cy = 2'(s13_yoe_r >= 9'd100) + 2'(s13_yoe_r >= 9'd200) + 2'(s13_yoe_r >= 9'd300);
    ys = us2cal_pkg::DOE_W'(us2cal_pkg::DOE_W'(s13_yoe_r)
                            * us2cal_pkg::DOE_W'(us2cal_pkg::DAYS_PER_YEAR))
       + us2cal_pkg::DOE_W'(s13_yoe_r[us2cal_pkg::YOE_W-1:2])
       - us2cal_pkg::DOE_W'(cy);
    dd = s13_doe_r - ys;
    s14_doy_nxt = dd[us2cal_pkg::DOY_W-1:0];
  end

  // Stage 15: month, day of month, year within the era and leap flag.
  always_comb begin
    logic [us2cal_pkg::DOY_W-1:0] md;
    logic jan;
    logic cent;
    logic quad;
    s15_mp_nxt = '0;
    for (int k = 1; k < 12; k++) begin
      s15_mp_nxt = s15_mp_nxt + 4'(s14_doy_r >= us2cal_pkg::month_start(4'(k)));
    end
    md          = s14_doy_r - us2cal_pkg::month_start(s15_mp_nxt) + 1'b1;
    s15_md_nxt  = md[us2cal_pkg::MDAY_W-1:0];
    jan         = s15_mp_nxt >= 4'(us2cal_pkg::FIRST_JAN_MP);
    s15_yy_nxt  = s14_yoe_r + us2cal_pkg::YOE_W'(jan);
    // Within an era the year is a century year at 0, 100, 200, 300 and 400,
    // and a multiple of 400 only at 0 and 400.
    quad = (s15_yy_nxt == 9'd0) || (s15_yy_nxt == 9'd400);
    cent = quad || (s15_yy_nxt == 9'd100) || (s15_yy_nxt == 9'd200)
                || (s15_yy_nxt == 9'd300);
    s15_leap_nxt = (s15_yy_nxt[1:0] == 2'b00) && (!cent || quad);
  end

  // Stage 16: January-based month, full year and day of year.
  always_comb begin
    logic [18:0] yr;
    if (s15_mp_r < 4'(us2cal_pkg::FIRST_JAN_MP)) begin
      s16_mon_nxt  = s15_mp_r + 4'd2;
      s16_yday_nxt = s15_doy_r + 9'(us2cal_pkg::JAN_FEB_DAYS) + 9'(s15_leap_r);
    end else begin
      s16_mon_nxt  = s15_mp_r - 4'(us2cal_pkg::FIRST_JAN_MP);
      s16_yday_nxt = s15_doy_r - 9'(us2cal_pkg::MARCH_TO_JAN);
    end
    yr = 19'(19'(s15_era_r) * 19'(us2cal_pkg::YEARS_PER_ERA)) + 19'(s15_yy_r)
       - 19'(us2cal_pkg::YEAR_BIAS);
    s16_year_nxt = yr[us2cal_pkg::YEAR_W-1:0];
  end

  // Data registers; all stages move together.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_x_r     <= s1_x_nxt;
      s1_lo_r    <= s1_lo_nxt;
      s2_pl_r    <= s2_pl_nxt;
      s2_ph_r    <= s2_ph_nxt;
      s2_x_r     <= s1_x_r;
      s2_lo_r    <= s1_lo_r;
      s3_qe_r    <= s3_qe_nxt;
      s3_x_r     <= s2_x_r;
      s3_lo_r    <= s2_lo_r;
      s4_qe_r    <= s3_qe_r;
      s4_re_r    <= s4_re_nxt;
      s4_lo_r    <= s3_lo_r;
      s5_q_r     <= s5_q_nxt;
      s5_sod_r   <= s5_sod_nxt;
      s6_q_r     <= s5_q_r;
      s6_sod_r   <= s5_sod_r;
      s6_era_r   <= s6_era_nxt;
      s6_ws_r    <= s6_ws_nxt;
      s6_he_r    <= s6_he_nxt;
      s7_era_r   <= s6_era_r;
      s7_doe_r   <= s7_doe_nxt;
      s7_wd_r    <= s7_wd_nxt;
      s7_h_r     <= s7_h_nxt;
      s7_rm_r    <= s7_rm_nxt;
      s8_era_r   <= s8_era_nxt;
      s8_doe_r   <= s8_doe_nxt;
      s8_wd_r    <= s7_wd_r;
      s8_h_r     <= s7_h_r;
      s8_rm_r    <= s7_rm_r;
      s8_me_r    <= s8_me_nxt;
      s9_era_r   <= s8_era_r;
      s9_doe_r   <= s8_doe_r;
      s9_c4e_r   <= s9_c4e_nxt;
      s9_cc_r    <= s9_cc_nxt;
      s9_tod_r   <= s9_tod_nxt;
      s10_era_r  <= s9_era_r;
      s10_doe_r  <= s9_doe_r;
      s10_c4_r   <= s10_c4_nxt;
      s10_cc_r   <= s9_cc_r;
      s10_tod_r  <= s9_tod_r;
      s11_era_r  <= s10_era_r;
      s11_doe_r  <= s10_doe_r;
      s11_n_r    <= s11_n_nxt;
      s11_tod_r  <= s10_tod_r;
      s12_era_r  <= s11_era_r;
      s12_doe_r  <= s11_doe_r;
      s12_n_r    <= s11_n_r;
      s12_ye_r   <= s12_ye_nxt;
      s12_tod_r  <= s11_tod_r;
      s13_era_r  <= s12_era_r;
      s13_doe_r  <= s12_doe_r;
      s13_yoe_r  <= s13_yoe_nxt;
      s13_tod_r  <= s12_tod_r;
      s14_era_r  <= s13_era_r;
      s14_yoe_r  <= s13_yoe_r;
      s14_doy_r  <= s14_doy_nxt;
      s14_tod_r  <= s13_tod_r;
      s15_era_r  <= s14_era_r;
      s15_doy_r  <= s14_doy_r;
      s15_mp_r   <= s15_mp_nxt;
      s15_md_r   <= s15_md_nxt;
      s15_yy_r   <= s15_yy_nxt;
      s15_leap_r <= s15_leap_nxt;
      s15_tod_r  <= s14_tod_r;
      s16_mon_r  <= s16_mon_nxt;
      s16_year_r <= s16_year_nxt;
      s16_yday_r <= s16_yday_nxt;
      s16_md_r   <= s15_md_r;
      s16_tod_r  <= s15_tod_r;
    end
  end

  // Output beat.
  assign out_valid            = v_r[NSTG-1];
  assign out_second           = s16_tod_r.second;
  assign out_minute           = s16_tod_r.minute;
  assign out_hour             = s16_tod_r.hour;
  assign out_weekday          = s16_tod_r.weekday;
  assign out_day_of_month     = s16_md_r;
  assign out_month_index      = s16_mon_r;
  assign out_years_since_1900 = $signed(s16_year_r);
  assign out_day_of_year      = s16_yday_r;

endmodule

@@ hdl/us2cal_checker.sv @@
module us2cal_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_valid,
  input logic                                   in_stall,
  input logic signed [us2cal_pkg::SECS_W-1:0]   in_unix_seconds,
  input logic                                   out_valid,
  input logic                                   out_stall,
  input logic        [us2cal_pkg::SEC_W-1:0]    out_second,
  input logic        [us2cal_pkg::MIN_W-1:0]    out_minute,
  input logic        [us2cal_pkg::HOUR_W-1:0]   out_hour,
  input logic        [us2cal_pkg::MDAY_W-1:0]   out_day_of_month,
  input logic        [us2cal_pkg::MON_W-1:0]    out_month_index,
  input logic signed [us2cal_pkg::YEAR_W-1:0]   out_years_since_1900,
  input logic        [us2cal_pkg::WDAY_W-1:0]   out_weekday,
  input logic        [us2cal_pkg::YDAY_W-1:0]   out_day_of_year
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat shown right after reset");

  // A stalled result beat stays offered with the same year, day of year and second.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_years_since_1900)
                               && $stable(out_day_of_year) && $stable(out_second))
    else $error("stalled result beat changed or dropped");

  // With no result waiting, the input side is never held off.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while the output is empty");

  // Each field but the year stays in range; the day of month is only checked to be nonzero.
  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_second < 6'd60 && out_minute < 6'd60 && out_hour < 5'd24
                  && out_month_index < 4'd12 && out_weekday < 3'd7
                  && out_day_of_month != 5'd0 && out_day_of_year < 9'd366)
    else $error("result field out of range");

  // In January the day of year follows the day of month.
  a_january: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_month_index == 4'd0
      |-> out_day_of_year == 9'(out_day_of_month) - 9'd1)
    else $error("January day of year disagrees with day of month");

endmodule

bind unix_seconds_to_calendar_top us2cal_checker u_us2cal_checker (.*);

@@ verif/tb_unix_seconds_to_calendar_top.sv @@
module tb_unix_seconds_to_calendar_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_LATENCY = 16;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int REPORT_MAX   = 10;

  typedef logic signed [us2cal_pkg::SECS_W-1:0] secs_t;

  // One broken-down UTC time, at the widths of the result ports.
  typedef struct {
    logic        [us2cal_pkg::SEC_W-1:0]  second;
    logic        [us2cal_pkg::MIN_W-1:0]  minute;
    logic        [us2cal_pkg::HOUR_W-1:0] hour;
    logic        [us2cal_pkg::MDAY_W-1:0] mday;
    logic        [us2cal_pkg::MON_W-1:0]  month;
    logic signed [us2cal_pkg::YEAR_W-1:0] years;
    logic        [us2cal_pkg::WDAY_W-1:0] weekday;
    logic        [us2cal_pkg::YDAY_W-1:0] yday;
  } calendar_t;

  typedef struct {
    secs_t     secs;
    calendar_t cal;
  } dated_secs_t;

  // Keeps the predicted dates of accepted timestamps in order and checks
  // each result beat against the oldest one.
  class date_scoreboard;
    dated_secs_t expected_dates[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    static function longint floor_div(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && ((a < 0) != (b < 0)))
        q -= 1;
      return q;
    endfunction

    // Floor split into days and seconds of day, then the era-based
    // proleptic Gregorian date from the day count.
    function calendar_t civil_from_secs(secs_t secs);
      calendar_t c;
      longint s, days, sod, z, era, doe, yoe, year, doy, mp, mday, mon, leap, yday, wday;
      s    = longint'(secs);
      days = floor_div(s, 86400);
      sod  = s - days * 86400;
      z    = days + 719468;
      era  = floor_div(z, 146097);
      doe  = z - era * 146097;
      yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      year = yoe + era * 400;
      doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp   = (5 * doy + 2) / 153;
      mday = doy - (153 * mp + 2) / 5 + 1;
      mon  = (mp < 10) ? mp + 3 : mp - 9;
      if (mon <= 2)
        year += 1;
      leap = (year % 4 == 0 && (year % 100 != 0 || year % 400 == 0)) ? 1 : 0;
      yday = (mp < 10) ? doy + 59 + leap : doy - 306;
      wday = (days + 4) - floor_div(days + 4, 7) * 7;
      c.second  = us2cal_pkg::SEC_W'(sod % 60);
      c.minute  = us2cal_pkg::MIN_W'((sod / 60) % 60);
      c.hour    = us2cal_pkg::HOUR_W'(sod / 3600);
      c.mday    = us2cal_pkg::MDAY_W'(mday);
      c.month   = us2cal_pkg::MON_W'(mon - 1);
      c.years   = us2cal_pkg::YEAR_W'(year - 1900);
      c.weekday = us2cal_pkg::WDAY_W'(wday);
      c.yday    = us2cal_pkg::YDAY_W'(yday);
      return c;
    endfunction

    function void note_input(secs_t secs);
      dated_secs_t d;
      d.secs = secs;
      d.cal  = civil_from_secs(secs);
      expected_dates.push_back(d);
    endfunction

    function void check_result(calendar_t got);
      dated_secs_t e;
      if (expected_dates.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result beat with no timestamp waiting: %0d-%0d-%0d %0d:%0d:%0d",
                   $realtime, got.years, got.month, got.mday, got.hour, got.minute,
                   got.second);
        return;
      end
      e = expected_dates.pop_front();
      if (got.second !== e.cal.second || got.minute !== e.cal.minute ||
          got.hour !== e.cal.hour || got.mday !== e.cal.mday ||
          got.month !== e.cal.month || got.years !== e.cal.years ||
          got.weekday !== e.cal.weekday || got.yday !== e.cal.yday) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("%0t: mismatch for seconds %0d", $realtime, e.secs);
          $display("  expected y%0d m%0d d%0d %0d:%0d:%0d wday %0d yday %0d",
                   e.cal.years, e.cal.month, e.cal.mday, e.cal.hour, e.cal.minute,
                   e.cal.second, e.cal.weekday, e.cal.yday);
          $display("  actual   y%0d m%0d d%0d %0d:%0d:%0d wday %0d yday %0d",
                   got.years, got.month, got.mday, got.hour, got.minute,
                   got.second, got.weekday, got.yday);
        end
      end
    endfunction

    function int pending();
      return expected_dates.size();
    endfunction
  endclass

  logic  clk             = 1'b0;
  logic  rst_n           = 1'b0;
  logic  in_valid        = 1'b0;
  secs_t in_unix_seconds = '0;
  logic  out_stall       = 1'b0;
  logic  in_stall;
  logic  out_valid;
  logic        [us2cal_pkg::SEC_W-1:0]  out_second;
  logic        [us2cal_pkg::MIN_W-1:0]  out_minute;
  logic        [us2cal_pkg::HOUR_W-1:0] out_hour;
  logic        [us2cal_pkg::MDAY_W-1:0] out_day_of_month;
  logic        [us2cal_pkg::MON_W-1:0]  out_month_index;
  logic signed [us2cal_pkg::YEAR_W-1:0] out_years_since_1900;
  logic        [us2cal_pkg::WDAY_W-1:0] out_weekday;
  logic        [us2cal_pkg::YDAY_W-1:0] out_day_of_year;

  date_scoreboard sb = new();
  bit tx_idle_en   = 1'b0;
  bit rx_idle_en   = 1'b0;
  bit hold_request = 1'b0;
  int unsigned cycle_count = 0;

  // Leap days, century years, year ends, epoch and range limits.
  longint directed_secs[] = '{
    0, -1, 1, 86399, 86400, -86400, -86401,
    64'sd1099511627775, -64'sd1099511627776,
    64'sd951782400, 64'sd951868799, 64'sd951868800, 64'sd946684800,
    -64'sd2208988800, -64'sd2203977600, -64'sd2203891200,
    64'sd4107456000, 64'sd4107542400,
    64'sd1709164800, 64'sd1735689599, 64'sd1735689600,
    -64'sd62167219200, -64'sd62167219201,
    -64'sd12219292800, 64'sd253402300799
  };

  unix_seconds_to_calendar_top u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_unix_seconds      (in_unix_seconds),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_second           (out_second),
    .out_minute           (out_minute),
    .out_hour             (out_hour),
    .out_day_of_month     (out_day_of_month),
    .out_month_index      (out_month_index),
    .out_years_since_1900 (out_years_since_1900),
    .out_weekday          (out_weekday),
    .out_day_of_year      (out_day_of_year)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** unix_seconds_to_calendar_top: FAILED **");
      $finish;
    end
  end

  // Both channels are observed here, input beats before result beats.
  always @(posedge clk) begin
    calendar_t got;
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.note_input(in_unix_seconds);
      if (out_valid && !out_stall) begin
        got.second  = out_second;
        got.minute  = out_minute;
        got.hour    = out_hour;
        got.mday    = out_day_of_month;
        got.month   = out_month_index;
        got.years   = out_years_since_1900;
        got.weekday = out_weekday;
        got.yday    = out_day_of_year;
        sb.check_result(got);
      end
    end
  end

  // Mostly no gap, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // Timestamps spread over the whole range, with many near day, year and
  // era boundaries and near the ends of the range.
  function automatic secs_t random_seconds();
    logic [63:0] r;
    longint      d, era, yoe, base, pick;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return r[us2cal_pkg::SECS_W-1:0];
      1: return secs_t'(longint'(int'(r[31:0])));
      2: begin
        d = longint'($urandom_range(0, 25000000)) - 12700000;
        if (r[40])
          return secs_t'(d * 86400 + $urandom_range(0, 2));
        return secs_t'(d * 86400 + 86399 - $urandom_range(0, 2));
      end
      3: begin
        era  = longint'($urandom_range(0, 165)) - 80;
        yoe  = $urandom_range(0, 399);
        base = yoe * 365 + yoe / 4 - yoe / 100;
        case ($urandom_range(0, 2))
          0: pick = 0;
          1: pick = 306;
          default: pick = 365;
        endcase
        d = era * 146097 + base + pick + $urandom_range(0, 2) - 1 - 719468;
        return secs_t'(d * 86400 + $urandom_range(0, 86399));
      end
      4: begin
        if (r[40])
          return secs_t'(64'sd1099511627775 - $urandom_range(0, 200000));
        return secs_t'(-64'sd1099511627776 + $urandom_range(0, 200000));
      end
      default: return secs_t'(-longint'($urandom_range(0, 1000000000)));
    endcase
  endfunction

  // Offers one timestamp and waits for its beat to be accepted.
  task automatic send_item(input secs_t secs);
    int gap;
    in_valid        <= 1'b1;
    in_unix_seconds <= secs;
    do @(posedge clk); while (in_stall);
    gap = tx_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid        <= 1'b0;
      in_unix_seconds <= random_seconds();
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops sending until every expected result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Receiver: random stalls, stall-free stretches and one long hold-off.
  initial begin : receiver
    int run;
    run = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        run = $urandom_range(5, 30);
      end else if (run > 0) begin
        run--;
      end else if (!rx_idle_en) begin
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 99) < 30) begin
        out_stall <= 1'b1;
        run = pick_gap();
      end else begin
        out_stall <= 1'b0;
        run = $urandom_range(0, 8);
      end
    end
  end

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed timestamps back to back.
    foreach (directed_secs[k])
      send_item(secs_t'(directed_secs[k]));
    wait_drained();

    // Random timestamps with idling on both sides.
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    repeat (700) send_item(random_seconds());

    // Long receiver hold-off while the sender keeps offering beats.
    tx_idle_en   = 1'b0;
    hold_request = 1'b1;
    repeat (60) send_item(random_seconds());
    wait_drained();

    // Full rate with no idling.
    rx_idle_en = 1'b0;
    repeat (500) send_item(random_seconds());
    wait_drained();

    // Idling again to the end.
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    repeat (565) send_item(random_seconds());
    wait_drained();
    repeat (PIPE_LATENCY + 8) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("** unix_seconds_to_calendar_top: PASSED **");
    else
      $display("** unix_seconds_to_calendar_top: FAILED **");
    $finish;
  end

endmodule

@@ unix_seconds_to_calendar_top.f @@
hdl/us2cal_pkg.sv
hdl/unix_seconds_to_calendar_top.sv
hdl/us2cal_checker.sv
verif/tb_unix_seconds_to_calendar_top.sv
